// ===== hw/rtl/arfc_pkg.sv =====
// Shared types, character codes and status codes for the ASCII response frame checker.
// No dependencies.
package arfc_pkg;

   localparam int unsigned DataWidth   = 8;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned AddrWidth   = 7;
   localparam int unsigned PosWidth    = 5;

   // Bytes at positions below this limit are summed (positions 0 to 29).
   localparam logic [PosWidth-1:0] MaxSumSpan = PosWidth'(30);
   localparam logic [PosWidth-1:0] PosMax     = PosWidth'(31);
   localparam logic [PosWidth-1:0] PosMinEnd  = PosWidth'(12);

   localparam logic [AddrWidth-1:0] OwnAddressReset = AddrWidth'(85);

   localparam logic [DataWidth-1:0] ChStart  = 8'h24;  // '$'
   localparam logic [DataWidth-1:0] ChStar   = 8'h2A;  // '*'
   localparam logic [DataWidth-1:0] ChZero   = 8'h30;  // '0'
   localparam logic [DataWidth-1:0] ChOne    = 8'h31;  // '1'
   localparam logic [DataWidth-1:0] ChNine   = 8'h39;  // '9'
   localparam logic [DataWidth-1:0] InsStart = 8'h31;  // '1'
   localparam logic [DataWidth-1:0] InsData  = 8'h34;  // '4'

   localparam logic [StatusWidth-1:0] StatStartOk  = 3'd0;
   localparam logic [StatusWidth-1:0] StatStartErr = 3'd1;
   localparam logic [StatusWidth-1:0] StatDataOk   = 3'd2;
   localparam logic [StatusWidth-1:0] StatDataErr  = 3'd3;
   localparam logic [StatusWidth-1:0] StatAddrErr  = 3'd4;
   localparam logic [StatusWidth-1:0] StatFrameErr = 3'd5;

   typedef struct packed {
      logic [DataWidth-1:0] data_byte;
      logic                 frame_start;
      logic                 frame_end;
   } arfc_item_type;

   typedef struct packed {
      logic [DataWidth-1:0] tens;
      logic [DataWidth-1:0] ones;
   } arfc_addr_chars_type;

   // Split a 7-bit ID into two ASCII characters; /10 via reciprocal 205/2048,
   // exact for all 7-bit values.
   function automatic arfc_addr_chars_type addr_chars(input logic [AddrWidth-1:0] addr);
      logic [15:0]          prod;
      logic [3:0]           quo;
      logic [AddrWidth-1:0] rem;
      arfc_addr_chars_type  res;
      prod     = 16'(addr) * 16'd205;
      quo      = prod[14:11];
      rem      = addr - (AddrWidth'(quo) * AddrWidth'(10));
      res.tens = ChZero + DataWidth'(quo);
      res.ones = ChZero + DataWidth'(rem);
      return res;
   endfunction

endpackage

// ===== hw/rtl/arfc_addr_cfg.sv =====
// Own-address register, kept as the two ASCII characters it is compared as.
// Depends on arfc_pkg.
module arfc_addr_cfg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [arfc_pkg::AddrWidth-1:0]     csr_wr_data,
   output arfc_pkg::arfc_addr_chars_type      chars
);

   arfc_pkg::arfc_addr_chars_type chars_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff <= arfc_pkg::addr_chars(arfc_pkg::OwnAddressReset);
      end else if (csr_wr_en) begin
         chars_ff <= arfc_pkg::addr_chars(csr_wr_data);
      end
   end

   assign chars = chars_ff;

endmodule

// ===== hw/rtl/arfc_in_stage.sv =====
// Input register for received frame bytes.
// Depends on arfc_pkg.
module arfc_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  arfc_pkg::arfc_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_advance,
   output arfc_pkg::arfc_item_type out_item
);

   logic                    valid_ff;
   logic                    valid_in;
   arfc_pkg::arfc_item_type item_ff;

   assign in_ready = !valid_ff || out_advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== hw/rtl/arfc_frame_check.sv =====
// Per-frame state (position, sum, field captures) and the end-of-frame status decision.
// Depends on arfc_pkg.
module arfc_frame_check #(
   parameter logic [arfc_pkg::PosWidth-1:0] MaxSumSpan = arfc_pkg::MaxSumSpan
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  arfc_pkg::arfc_item_type              item,
   input  arfc_pkg::arfc_addr_chars_type        chars,
   output logic [arfc_pkg::StatusWidth-1:0]     status
);

   localparam int unsigned DW = arfc_pkg::DataWidth;
   localparam int unsigned PW = arfc_pkg::PosWidth;

   logic [PW-1:0] position_ff, position_in;
   logic [DW-1:0] sum_ff, sum_in;
   logic          closed_ff, closed_in;
   logic          start_ok_ff, start_ok_in;
   logic          addr_ok_ff, addr_ok_in;
   logic [DW-1:0] instr_ff, instr_in;
   logic          digit_one_ff, digit_one_in;
   logic [DW-1:0] cksum_ff, cksum_in;
   logic          stopped_ff, stopped_in;

   // frame state after an optional start clear
   logic [PW-1:0] pos;
   logic [DW-1:0] b_sum, u_sum;
   logic          b_closed, u_closed;
   logic          b_start_ok, u_start_ok;
   logic          b_addr_ok, u_addr_ok;
   logic [DW-1:0] b_instr, u_instr;
   logic          b_digit_one, u_digit_one;
   logic [DW-1:0] b_cksum, u_cksum;
   logic          b_stopped, u_stopped;
   logic [DW-1:0] byte_val;
   logic          is_digit;

   assign byte_val = item.data_byte;
   assign is_digit = (byte_val >= arfc_pkg::ChZero) && (byte_val <= arfc_pkg::ChNine);

   always_comb begin
      pos         = item.frame_start ? '0 : position_ff;
      b_sum       = item.frame_start ? '0 : sum_ff;
      b_closed    = item.frame_start ? 1'b0 : closed_ff;
      b_start_ok  = item.frame_start ? 1'b0 : start_ok_ff;
      b_addr_ok   = item.frame_start ? 1'b0 : addr_ok_ff;
      b_instr     = item.frame_start ? '0 : instr_ff;
      b_digit_one = item.frame_start ? 1'b0 : digit_one_ff;
      b_cksum     = item.frame_start ? '0 : cksum_ff;
      b_stopped   = item.frame_start ? 1'b0 : stopped_ff;

      u_sum       = b_sum;
      u_closed    = b_closed;
      if (!b_closed && (pos < MaxSumSpan)) begin
         u_sum    = b_sum + byte_val;
         u_closed = (byte_val == arfc_pkg::ChStar);
      end

      u_start_ok  = b_start_ok;
      u_addr_ok   = b_addr_ok;
      u_instr     = b_instr;
      u_digit_one = b_digit_one;
      u_cksum     = b_cksum;
      u_stopped   = b_stopped;
      case (pos)
         PW'(0): u_start_ok  = (byte_val == arfc_pkg::ChStart);
         PW'(1): u_addr_ok   = (byte_val == chars.tens);
         PW'(2): u_addr_ok   = b_addr_ok && (byte_val == chars.ones);
         PW'(4): u_instr     = byte_val;
         PW'(8): u_digit_one = (byte_val == arfc_pkg::ChOne);
         PW'(10), PW'(11), PW'(12): begin
            if (!b_stopped) begin
               if (is_digit) begin
                  // cksum*10 + digit, mod 256
                  u_cksum = (b_cksum << 3) + (b_cksum << 1) + (byte_val - arfc_pkg::ChZero);
               end else begin
                  u_stopped = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      if (pos < arfc_pkg::PosMinEnd) begin
         status = arfc_pkg::StatFrameErr;
      end else if (!u_start_ok) begin
         status = arfc_pkg::StatFrameErr;
      end else if (!u_addr_ok) begin
         status = arfc_pkg::StatAddrErr;
      end else if (u_sum != u_cksum) begin
         status = arfc_pkg::StatFrameErr;
      end else if (u_instr == arfc_pkg::InsStart) begin
         status = u_digit_one ? arfc_pkg::StatStartOk : arfc_pkg::StatStartErr;
      end else if (u_instr == arfc_pkg::InsData) begin
         status = u_digit_one ? arfc_pkg::StatDataOk : arfc_pkg::StatDataErr;
      end else begin
         status = arfc_pkg::StatFrameErr;
      end
   end

   // frame end clears everything, so the next byte lands at position 0
   always_comb begin
      if (item.frame_end) begin
         position_in  = '0;
         sum_in       = '0;
         closed_in    = 1'b0;
         start_ok_in  = 1'b0;
         addr_ok_in   = 1'b0;
         instr_in     = '0;
         digit_one_in = 1'b0;
         cksum_in     = '0;
         stopped_in   = 1'b0;
      end else begin
         position_in  = (pos < arfc_pkg::PosMax) ? pos + PW'(1) : pos;
         sum_in       = u_sum;
         closed_in    = u_closed;
         start_ok_in  = u_start_ok;
         addr_ok_in   = u_addr_ok;
         instr_in     = u_instr;
         digit_one_in = u_digit_one;
         cksum_in     = u_cksum;
         stopped_in   = u_stopped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         sum_ff       <= '0;
         closed_ff    <= 1'b0;
         start_ok_ff  <= 1'b0;
         addr_ok_ff   <= 1'b0;
         instr_ff     <= '0;
         digit_one_ff <= 1'b0;
         cksum_ff     <= '0;
         stopped_ff   <= 1'b0;
      end else if (fire) begin
         position_ff  <= position_in;
         sum_ff       <= sum_in;
         closed_ff    <= closed_in;
         start_ok_ff  <= start_ok_in;
         addr_ok_ff   <= addr_ok_in;
         instr_ff     <= instr_in;
         digit_one_ff <= digit_one_in;
         cksum_ff     <= cksum_in;
         stopped_ff   <= stopped_in;
      end
   end

endmodule

// ===== hw/rtl/arfc_out_stage.sv =====
// Result register holding one frame status until the downstream side takes it.
// Depends on arfc_pkg.
module arfc_out_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   output logic                              load_ready,
   input  logic [arfc_pkg::StatusWidth-1:0]  status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [arfc_pkg::DataWidth-1:0]    rsp_tdata
);

   logic                             valid_ff, valid_in;
   logic [arfc_pkg::StatusWidth-1:0] status_ff;

   assign load_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load_ready) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_ready) begin
         status_ff <= status;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(arfc_pkg::DataWidth-arfc_pkg::StatusWidth){1'b0}}, status_ff};

endmodule

// ===== hw/rtl/ascii_response_frame_checker.sv =====
// Response frame checker: input register, per-byte frame tracking, status result register.
// Depends on arfc_pkg, arfc_addr_cfg, arfc_in_stage, arfc_frame_check, arfc_out_stage.
// A frame-end byte's status reaches rsp via the input register, then the result register.
// Throughput: one byte per cycle; only a frame-end byte waits, while the result register
// still holds an untaken status.
// Reset (synchronous): clears frame state and valids; own address returns to 85.
module ascii_response_frame_checker #(
   parameter logic [arfc_pkg::PosWidth-1:0] MaxSumSpan = arfc_pkg::MaxSumSpan
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [arfc_pkg::DataWidth-1:0] req_tdata,  // [7:0] data_byte
   input  logic                           req_tuser,  // [0] frame_start
   input  logic                           req_tlast,  // frame_end
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [arfc_pkg::DataWidth-1:0] rsp_tdata,  // [2:0] status, [7:3] zero
   input  logic                           csr_wr_en,
   input  logic [arfc_pkg::AddrWidth-1:0] csr_wr_data
);

   arfc_pkg::arfc_item_type          req_item;
   arfc_pkg::arfc_item_type          s1_item;
   arfc_pkg::arfc_addr_chars_type    chars;
   logic                             s1_valid;
   logic                             s1_fire;
   logic                             out_ready;
   logic                             out_load;
   logic [arfc_pkg::StatusWidth-1:0] status;

   assign req_item.data_byte   = req_tdata;
   assign req_item.frame_start = req_tuser;
   assign req_item.frame_end   = req_tlast;

   arfc_addr_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .chars       (chars)
   );

   arfc_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_item     (req_item),
      .out_valid   (s1_valid),
      .out_advance (s1_fire),
      .out_item    (s1_item)
   );

   // bytes that end no frame never wait on the result side
   assign s1_fire  = s1_valid && (!s1_item.frame_end || out_ready);
   assign out_load = s1_fire && s1_item.frame_end;

   arfc_frame_check #(
      .MaxSumSpan (MaxSumSpan)
   ) u_check (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .item   (s1_item),
      .chars  (chars),
      .status (status)
   );

   arfc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .load_ready (out_ready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_load_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("status loaded over an untaken result");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("loaded status not presented");

   a_mid_frame_flows: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && !s1_item.frame_end) |-> req_tready)
      else $error("mid-frame byte stalled the input");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata <= arfc_pkg::DataWidth'(arfc_pkg::StatFrameErr)))
      else $error("status code out of range");

endmodule
